@@ rtl/msw_pkg.sv @@
// Shared constants and types of the 3x3 window-sum search block.
`default_nettype none

package msw_pkg;

    // Default build parameters
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int PIXEL_BITS_DEF  = 8;

    // Window and frame limits
    localparam int WIN        = 3;
    localparam int ROW_LIMIT  = 1024;
    localparam int SIZE_RESET = 3;

    // Port field widths
    localparam int PIXEL_W   = 8;
    localparam int SUM_W     = 12;
    localparam int POS_W     = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT    = 1'b0,
        CFG_COLUMN_COUNT = 1'b1
    } cfg_index_t;

endpackage

`default_nettype wire

@@ rtl/msw_if.sv @@
// Valid/ready channel interfaces for pixel items and result items.
`default_nettype none

interface msw_pixel_if;
    logic                       valid;
    logic                       ready;
    logic [msw_pkg::PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface msw_result_if;
    logic                      valid;
    logic                      ready;
    logic [msw_pkg::SUM_W-1:0] best_sum;
    logic [msw_pkg::POS_W-1:0] best_row;
    logic [msw_pkg::POS_W-1:0] best_column;

    modport source (output valid, output best_sum, output best_row, output best_column,
                    input ready);
    modport sink   (input valid, input best_sum, input best_row, input best_column,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/msw_line_mem.sv @@
// Single-port-read, single-port-write line memory with registered read data.
`default_nettype none

module msw_line_mem #(
    parameter int DEPTH = msw_pkg::MAX_COLUMNS_DEF,
    parameter int WIDTH = 2 * msw_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/max_sum_3x3_window_search.sv @@
// Top level of the streaming 3x3 window-sum search.
`default_nettype none

// Takes one pixel item per cycle in raster order and, after the last pixel of
// each frame, emits one result item: the largest 3x3 window sum of the frame
// and the top-left row and column of that window (first maximum in raster
// order wins; an all-zero frame reports sum 0 at row 0, column 0). The frame
// size comes from row_count (index 0) and column_count (index 1); values below
// 3 act as 3, values above the limit act as the limit (1024 rows, MAX_COLUMNS
// columns). Writing either register restarts the frame. Throughput is one
// pixel per cycle, set by the single line memory that is read at the pixel's
// column in the accept cycle and written back in the cycle after. The last
// pixel of a frame is held off while the previous result has not been
// taken; all other pixels are accepted while a result waits at the output.
module max_sum_3x3_window_search #(
    parameter int MAX_COLUMNS = msw_pkg::MAX_COLUMNS_DEF,
    parameter int PIXEL_BITS  = msw_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    msw_pixel_if.sink                          pixels,
    msw_result_if.source                       results,
    input  wire logic                          cfg_we,
    input  wire logic [msw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [msw_pkg::CFG_W-1:0]     cfg_data
);

    localparam int COL_W    = $clog2(MAX_COLUMNS);
    localparam int COLS_W   = COL_W + 1;
    localparam int POS_W    = msw_pkg::POS_W;
    localparam int CFG_W    = msw_pkg::CFG_W;
    localparam int SUM_FULL = msw_pkg::WIN * msw_pkg::WIN * ((1 << PIXEL_BITS) - 1);
    localparam int SUM_W    = $clog2(SUM_FULL + 1);

    // ------------------------------------------------------------------
    // Configuration registers and effective frame size
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  row_count_reg;
    logic [CFG_W-1:0]  column_count_reg;
    logic [CFG_W-1:0]  rows_eff;
    logic [31:0]       cols_ext;
    logic [31:0]       cols_clamped;
    logic [COLS_W-1:0] cols_eff;

    always_comb
    begin
        if (row_count_reg < CFG_W'(msw_pkg::SIZE_RESET))
        begin
            rows_eff = CFG_W'(msw_pkg::SIZE_RESET);
        end
        else if (row_count_reg > CFG_W'(msw_pkg::ROW_LIMIT))
        begin
            rows_eff = CFG_W'(msw_pkg::ROW_LIMIT);
        end
        else
        begin
            rows_eff = row_count_reg;
        end
    end

    always_comb
    begin
        cols_ext = 32'(column_count_reg);
        if (cols_ext < 32'(msw_pkg::SIZE_RESET))
        begin
            cols_clamped = 32'(msw_pkg::SIZE_RESET);
        end
        else if (cols_ext > 32'(MAX_COLUMNS))
        begin
            cols_clamped = 32'(MAX_COLUMNS);
        end
        else
        begin
            cols_clamped = cols_ext;
        end
        cols_eff = cols_clamped[COLS_W-1:0];
    end

    logic cfg_row_we;
    logic cfg_col_we;

    always_comb
    begin
        cfg_row_we = 1'b0;
        cfg_col_we = 1'b0;
        case (msw_pkg::cfg_index_t'(cfg_index))
            msw_pkg::CFG_ROW_COUNT:    cfg_row_we = cfg_we;
            msw_pkg::CFG_COLUMN_COUNT: cfg_col_we = cfg_we;
            default:
            begin
                cfg_row_we = 1'b0;
                cfg_col_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= CFG_W'(msw_pkg::SIZE_RESET);
            column_count_reg <= CFG_W'(msw_pkg::SIZE_RESET);
        end
        else
        begin
            if (cfg_row_we)
            begin
                row_count_reg <= cfg_data;
            end
            if (cfg_col_we)
            begin
                column_count_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Raster position and input handshake
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  col_pos_reg;
    logic [POS_W-1:0]  row_pos_reg;
    logic [COLS_W-1:0] col_plus;
    logic [CFG_W-1:0]  row_plus;
    logic              col_end;
    logic              row_end;
    logic              frame_last;
    logic              result_busy;
    logic              accept;

    // pipeline flags, declared here for the ready guard
    logic s1_valid_reg;
    logic s1_last_reg;
    logic s2_valid_reg;
    logic s2_last_reg;
    logic s3_valid_reg;
    logic s3_last_reg;
    logic out_valid_reg;

    assign col_plus   = COLS_W'(col_pos_reg) + COLS_W'(1);
    assign row_plus   = CFG_W'(row_pos_reg) + CFG_W'(1);
    assign col_end    = (col_plus == cols_eff);
    assign row_end    = (row_plus == rows_eff);
    assign frame_last = col_end && row_end;

    // Hold the last pixel of a frame while a result still occupies the output
    // path, so that at most one result is ever in flight.
    assign result_busy = out_valid_reg
                       || (s1_valid_reg && s1_last_reg)
                       || (s2_valid_reg && s2_last_reg)
                       || (s3_valid_reg && s3_last_reg);

    assign pixels.ready = !(frame_last && result_busy);
    assign accept       = pixels.valid && pixels.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (cfg_we)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (accept)
        begin
            if (col_end)
            begin
                col_pos_reg <= '0;
                if (row_end)
                begin
                    row_pos_reg <= '0;
                end
                else
                begin
                    row_pos_reg <= row_plus[POS_W-1:0];
                end
            end
            else
            begin
                col_pos_reg <= col_plus[COL_W-1:0];
            end
        end
    end

    // Keep only the low PIXEL_BITS of the incoming pixel.
    logic [15:0]           pixel_wide;
    logic [PIXEL_BITS-1:0] px_in;

    assign pixel_wide = 16'(pixels.pixel);
    assign px_in      = pixel_wide[PIXEL_BITS-1:0];

    // ------------------------------------------------------------------
    // Line memory: entry holds {upper row, middle row} for one column
    // ------------------------------------------------------------------
    logic [2*PIXEL_BITS-1:0] mem_rd_data;
    logic [PIXEL_BITS-1:0]   line_top;
    logic [PIXEL_BITS-1:0]   line_mid;
    logic [COL_W-1:0]        s1_col_reg;
    logic [POS_W-1:0]        s1_row_reg;
    logic [PIXEL_BITS-1:0]   s1_px_reg;

    assign line_top = mem_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
    assign line_mid = mem_rd_data[PIXEL_BITS-1:0];

    // Consecutive items always address different columns (at least three
    // columns per row), so the write-back never races the next read.
    msw_line_mem #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (2 * PIXEL_BITS)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_pos_reg),
        .rd_data (mem_rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({line_mid, s1_px_reg})
    );

    // ------------------------------------------------------------------
    // Stage 1: memory data returns, window shifts, line entry written back
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_last_reg  <= accept && frame_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg <= col_pos_reg;
            s1_row_reg <= row_pos_reg;
            s1_px_reg  <= px_in;
        end
    end

    // window cells: [row][column], newest column on the right
    logic [PIXEL_BITS-1:0] win_reg [msw_pkg::WIN][msw_pkg::WIN];

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            for (int k = 0; k < msw_pkg::WIN; k++)
            begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= line_top;
            win_reg[1][2] <= line_mid;
            win_reg[2][2] <= s1_px_reg;
        end
    end

    logic             s2_check_reg;
    logic [POS_W-1:0] s2_row_reg;
    logic [COL_W-1:0] s2_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_valid_reg && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_check_reg <= (s1_row_reg >= POS_W'(2)) && (s1_col_reg >= COL_W'(2));
            s2_row_reg   <= s1_row_reg - POS_W'(2);
            s2_col_reg   <= s1_col_reg - COL_W'(2);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sum the nine window cells
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] win_sum;

    always_comb
    begin
        win_sum = '0;
        for (int i = 0; i < msw_pkg::WIN; i++)
        begin
            for (int j = 0; j < msw_pkg::WIN; j++)
            begin
                win_sum = win_sum + SUM_W'(win_reg[i][j]);
            end
        end
    end

    logic             s3_check_reg;
    logic [POS_W-1:0] s3_row_reg;
    logic [COL_W-1:0] s3_col_reg;
    logic [SUM_W-1:0] s3_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s3_last_reg  <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
            s3_last_reg  <= s2_valid_reg && s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_check_reg <= s2_check_reg;
            s3_row_reg   <= s2_row_reg;
            s3_col_reg   <= s2_col_reg;
            s3_sum_reg   <= win_sum;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: compare against the best so far; emit at end of frame
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] best_sum_reg;
    logic [POS_W-1:0] best_row_reg;
    logic [COL_W-1:0] best_col_reg;
    logic             take_new;
    logic [SUM_W-1:0] best_sum_next;
    logic [POS_W-1:0] best_row_next;
    logic [COL_W-1:0] best_col_next;

    // Only a strictly greater sum replaces the best: first maximum wins.
    assign take_new = s3_valid_reg && s3_check_reg && (s3_sum_reg > best_sum_reg);

    always_comb
    begin
        if (take_new)
        begin
            best_sum_next = s3_sum_reg;
            best_row_next = s3_row_reg;
            best_col_next = s3_col_reg;
        end
        else
        begin
            best_sum_next = best_sum_reg;
            best_row_next = best_row_reg;
            best_col_next = best_col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sum_reg <= '0;
            best_row_reg <= '0;
            best_col_reg <= '0;
        end
        else if (cfg_we || (s3_valid_reg && s3_last_reg))
        begin
            // restart the search for the next frame
            best_sum_reg <= '0;
            best_row_reg <= '0;
            best_col_reg <= '0;
        end
        else
        begin
            best_sum_reg <= best_sum_next;
            best_row_reg <= best_row_next;
            best_col_reg <= best_col_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [31:0]               sum_ext;
    logic [31:0]               col_ext;
    logic [msw_pkg::SUM_W-1:0] out_sum_reg;
    logic [POS_W-1:0]          out_row_reg;
    logic [msw_pkg::POS_W-1:0] out_col_reg;

    assign sum_ext = 32'(best_sum_next);
    assign col_ext = 32'(best_col_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s3_valid_reg && s3_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && s3_last_reg)
        begin
            out_sum_reg <= sum_ext[msw_pkg::SUM_W-1:0];
            out_row_reg <= best_row_next;
            out_col_reg <= col_ext[msw_pkg::POS_W-1:0];
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.best_sum    = out_sum_reg;
    assign results.best_row    = out_row_reg;
    assign results.best_column = out_col_reg;

endmodule

`default_nettype wire

@@ tb/tb_max_sum_3x3_window_search.sv @@
// Self-checking testbench for the streaming 3x3 window-sum search block.
module tb_max_sum_3x3_window_search;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESULT_LATENCY = 3;
    localparam int DRAIN_CYCLES   = RESULT_LATENCY + 4;
    // The long hold-off on the result side must stay well below the watchdog.
    localparam int HOLD_CYCLES    = 400;
    localparam int STALL_LIMIT    = 4000;
    localparam int PHASE_ITEMS    = 420;
    localparam int LIMIT_ITEMS    = 30;

    // How the pixels of one frame are filled.
    typedef enum int {
        FILL_ZERO,
        FILL_FULL,
        FILL_UNIFORM,
        FILL_LOW,
        FILL_SPARSE,
        FILL_PEAK_END
    } fill_t;

    typedef struct packed {
        logic [msw_pkg::SUM_W-1:0] best_sum;
        logic [msw_pkg::POS_W-1:0] best_row;
        logic [msw_pkg::POS_W-1:0] best_column;
    } best_window_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [msw_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [msw_pkg::CFG_W-1:0]     cfg_data;

    msw_pixel_if  pix_ch ();
    msw_result_if res_ch ();

    max_sum_3x3_window_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_ch),
        .results   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Knobs for the idling of both sides, in percent of cycles.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    bit          hold_results  = 1'b0;

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    // Expected best windows, oldest first.
    best_window_t expected_best[$];

    // Shadow of the block: size registers, line stores, window and running best.
    bit [msw_pkg::CFG_W-1:0]   row_count_reg    = msw_pkg::CFG_W'(msw_pkg::SIZE_RESET);
    bit [msw_pkg::CFG_W-1:0]   column_count_reg = msw_pkg::CFG_W'(msw_pkg::SIZE_RESET);
    bit [msw_pkg::PIXEL_W-1:0] upper_line [msw_pkg::MAX_COLUMNS_DEF];
    bit [msw_pkg::PIXEL_W-1:0] middle_line [msw_pkg::MAX_COLUMNS_DEF];
    bit [msw_pkg::PIXEL_W-1:0] window_px [9];
    int unsigned               row_pos    = 0;
    int unsigned               col_pos    = 0;
    int unsigned               best_total = 0;
    int unsigned               best_r     = 0;
    int unsigned               best_c     = 0;

    // Map a size register onto the frame size it stands for.
    function automatic int unsigned clamp_size(bit [msw_pkg::CFG_W-1:0] value,
                                               int unsigned limit);
        if (value < msw_pkg::WIN)
            return msw_pkg::WIN;
        if (value > limit)
            return limit;
        return value;
    endfunction

    // Clear position, window and best; the line stores survive a restart.
    function automatic void restart_search();
        foreach (window_px[k])
            window_px[k] = '0;
        row_pos    = 0;
        col_pos    = 0;
        best_total = 0;
        best_r     = 0;
        best_c     = 0;
    endfunction

    // Advance the shadow by one accepted pixel; queue the best window when
    // the pixel closes its frame.
    function automatic void advance_window_search(bit [msw_pkg::PIXEL_W-1:0] px);
        int unsigned               rows;
        int unsigned               cols;
        int unsigned               total;
        bit [msw_pkg::PIXEL_W-1:0] top;
        bit [msw_pkg::PIXEL_W-1:0] mid;
        best_window_t              entry;

        rows = clamp_size(row_count_reg, msw_pkg::ROW_LIMIT);
        cols = clamp_size(column_count_reg, msw_pkg::MAX_COLUMNS_DEF);

        top = upper_line[col_pos];
        mid = middle_line[col_pos];
        upper_line[col_pos]  = mid;
        middle_line[col_pos] = px;

        // Shift the window one column left and bring in the new column.
        for (int k = 0; k < msw_pkg::WIN; k++)
        begin
            window_px[k*msw_pkg::WIN]     = window_px[k*msw_pkg::WIN + 1];
            window_px[k*msw_pkg::WIN + 1] = window_px[k*msw_pkg::WIN + 2];
        end
        window_px[2] = top;
        window_px[5] = mid;
        window_px[8] = px;

        // Only a strictly larger sum wins, so the first maximum stays.
        if (row_pos >= 2 && col_pos >= 2)
        begin
            total = 0;
            foreach (window_px[k])
                total += window_px[k];
            if (total > best_total)
            begin
                best_total = total;
                best_r     = row_pos - 2;
                best_c     = col_pos - 2;
            end
        end

        if (col_pos + 1 < cols)
        begin
            col_pos++;
            return;
        end
        col_pos = 0;
        if (row_pos + 1 < rows)
        begin
            row_pos++;
            return;
        end

        entry.best_sum    = best_total[msw_pkg::SUM_W-1:0];
        entry.best_row    = best_r[msw_pkg::POS_W-1:0];
        entry.best_column = best_c[msw_pkg::POS_W-1:0];
        expected_best.push_back(entry);
        restart_search();
    endfunction

    function automatic bit [msw_pkg::PIXEL_W-1:0] pick_pixel(fill_t fill,
                                                             int unsigned r,
                                                             int unsigned c,
                                                             int unsigned rows,
                                                             int unsigned cols);
        case (fill)
            FILL_ZERO:    return '0;
            FILL_FULL:    return '1;
            FILL_LOW:     return msw_pkg::PIXEL_W'($urandom_range(3));
            FILL_SPARSE:  return ($urandom_range(3) == 0) ? '1 : '0;
            // Only the bottom-right window is all ones, so it must win.
            FILL_PEAK_END:
                return (r >= rows - msw_pkg::WIN && c >= cols - msw_pkg::WIN) ?
                       '1 : msw_pkg::PIXEL_W'($urandom_range(254));
            default:      return msw_pkg::PIXEL_W'($urandom_range(255));
        endcase
    endfunction

    // Mostly small sizes, some below the legal range, a few wider ones.
    function automatic bit [msw_pkg::CFG_W-1:0] pick_size();
        case ($urandom_range(9))
            0:       return msw_pkg::CFG_W'($urandom_range(2));
            1:       return msw_pkg::CFG_W'($urandom_range(7, 24));
            default: return msw_pkg::CFG_W'($urandom_range(3, 6));
        endcase
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one pixel item, idling first at random; return once it is taken.
    task automatic send_pixel(bit [msw_pkg::PIXEL_W-1:0] px);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_ch.valid = 1'b0;
            @(negedge clk);
        end
        pix_ch.valid = 1'b1;
        pix_ch.pixel = px;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        advance_window_search(px);
    endtask

    // Send the first count pixels of a frame at the current size.
    task automatic stream_frame(fill_t fill, int unsigned count);
        int unsigned rows;
        int unsigned cols;

        rows = clamp_size(row_count_reg, msw_pkg::ROW_LIMIT);
        cols = clamp_size(column_count_reg, msw_pkg::MAX_COLUMNS_DEF);
        for (int unsigned i = 0; i < count; i++)
            send_pixel(pick_pixel(fill, i / cols, i % cols, rows, cols));
    endtask

    // Drop valid, let every expected result arrive, then give the block
    // time to finish any pixel that produced nothing.
    task automatic wait_for_idle();
        @(negedge clk);
        pix_ch.valid = 1'b0;
        while (expected_best.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one size register; any write restarts the frame.
    task automatic write_size(msw_pkg::cfg_index_t index, bit [msw_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (index == msw_pkg::CFG_ROW_COUNT)
            row_count_reg = value;
        else
            column_count_reg = value;
        restart_search();
    endtask

    // Equal windows everywhere, all at the largest sum: the leftmost must win.
    task automatic test_equal_windows();
        write_size(msw_pkg::CFG_COLUMN_COUNT, msw_pkg::CFG_W'(4));
        stream_frame(FILL_FULL, 12);
    endtask

    // Abandon a frame part way, restart it with sizes below the legal range,
    // then send an all-zero frame: sum 0 at row 0, column 0.
    task automatic test_restart_zero_frame();
        wait_for_idle();
        stream_frame(FILL_FULL, 3);
        wait_for_idle();
        write_size(msw_pkg::CFG_ROW_COUNT, msw_pkg::CFG_W'(0));
        write_size(msw_pkg::CFG_COLUMN_COUNT, msw_pkg::CFG_W'(2));
        stream_frame(FILL_ZERO, 9);
    endtask

    // Sizes above the limits: the frame must stay open past the small sizes,
    // and the restart that follows must drop the partial frame cleanly.
    task automatic test_size_limits();
        wait_for_idle();
        write_size(msw_pkg::CFG_ROW_COUNT, '1);
        write_size(msw_pkg::CFG_COLUMN_COUNT, msw_pkg::CFG_W'(3));
        stream_frame(FILL_PEAK_END, LIMIT_ITEMS);
        wait_for_idle();
        write_size(msw_pkg::CFG_ROW_COUNT, msw_pkg::CFG_W'(2));
        write_size(msw_pkg::CFG_COLUMN_COUNT, '1);
        stream_frame(FILL_PEAK_END, LIMIT_ITEMS);
    endtask

    // Random frames; now and then cut a frame short and restart with new sizes.
    task automatic test_random_frames(int unsigned idle_pct, int unsigned hold_pct);
        int unsigned sent;
        int unsigned frame_len;
        int unsigned count;
        int unsigned which;
        bit          must_write;

        sent       = 0;
        must_write = 1'b1;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        while (sent < PHASE_ITEMS)
        begin
            if (must_write || $urandom_range(2) == 0)
            begin
                wait_for_idle();
                which = $urandom_range(2);
                if (which != 1)
                    write_size(msw_pkg::CFG_ROW_COUNT, pick_size());
                if (which != 0)
                    write_size(msw_pkg::CFG_COLUMN_COUNT, pick_size());
            end
            frame_len = clamp_size(row_count_reg, msw_pkg::ROW_LIMIT) *
                        clamp_size(column_count_reg, msw_pkg::MAX_COLUMNS_DEF);
            if ($urandom_range(9) == 0)
            begin
                count      = $urandom_range(frame_len - 1, 1);
                must_write = 1'b1;
            end
            else
            begin
                count      = frame_len;
                must_write = 1'b0;
            end
            stream_frame(fill_t'($urandom_range(FILL_PEAK_END, FILL_UNIFORM)), count);
            sent += count;
        end
    endtask

    // Hold the result side off for a long stretch while pixels keep coming,
    // so the block fills up and stalls the last pixel of a frame.
    task automatic test_output_backpressure();
        wait_for_idle();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_size(msw_pkg::CFG_ROW_COUNT, msw_pkg::CFG_W'(3));
        write_size(msw_pkg::CFG_COLUMN_COUNT, msw_pkg::CFG_W'(3));
        fork
            begin
                hold_results = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            begin
                repeat (4) stream_frame(FILL_UNIFORM, 9);
            end
        join
    endtask

    // Result side: stall at random, or hold off entirely while asked to.
    always @(negedge clk)
    begin
        res_ch.ready = !hold_results && ($urandom_range(99) >= stall_pct);
    end

    // Compare each taken result with the oldest expected best window.
    always @(posedge clk)
    begin : check_results
        best_window_t want;

        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_best.size() == 0)
            begin
                report_mismatch("result with none expected, best_sum",
                                32'(res_ch.best_sum), 0);
            end
            else
            begin
                want = expected_best.pop_front();
                if (res_ch.best_sum !== want.best_sum)
                    report_mismatch("best_sum", 32'(res_ch.best_sum),
                                    32'(want.best_sum));
                if (res_ch.best_row !== want.best_row)
                    report_mismatch("best_row", 32'(res_ch.best_row),
                                    32'(want.best_row));
                if (res_ch.best_column !== want.best_column)
                    report_mismatch("best_column", 32'(res_ch.best_column),
                                    32'(want.best_column));
            end
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    always @(posedge clk)
    begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        pix_ch.valid  = 1'b0;
        pix_ch.pixel  = '0;
        res_ch.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = msw_pkg::CFG_ROW_COUNT;
        cfg_data      = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_equal_windows();
        test_restart_zero_frame();
        test_size_limits();
        test_random_frames(0, 0);
        test_output_backpressure();
        test_random_frames(81, 0);
        test_random_frames(0, 81);
        test_random_frames(36, 36);

        // Drain: every expectation met, then a further wait for strays.
        wait_for_idle();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
